// ===== hw/rtl/bba_pkg.sv =====
// Package for the buddy block allocator.
// Holds default sizes, field widths, status codes, the controller command set
// and the datapath status bundle. Depends on nothing.
`timescale 1ns / 1ps

package bba_pkg;

  localparam int DEF_MIN_ORDER    = 6;
  localparam int DEF_MAX_ORDER    = 16;
  localparam int DEF_REGIONS      = 4;
  localparam int DEF_HEADER_BYTES = 16;

  localparam int LEN_W    = 16;
  localparam int ADDR_W   = 18;
  localparam int ORDER_W  = 5;
  localparam int STATUS_W = 2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_MEM    = 2'd2;

  typedef enum logic [4:0] {
    C_NOP,
    C_LOAD,
    C_SIZE,
    C_SCAN_INC,
    C_CLAIM,
    C_POP,
    C_UL_W1,
    C_UL_W2,
    C_SDEC,
    C_PUSH1,
    C_PUSH1M,
    C_PUSH2,
    C_PUSH2F,
    C_FINAL,
    C_FCHK,
    C_FUSED,
    C_MBUDDY,
    C_MUP,
    C_FPREP,
    C_R_OK,
    C_R_BIG,
    C_R_OOM
  } cmd_t;

  typedef struct packed {
    logic too_large;
    logic head_hit;
    logic k_is_max;
    logic regions_full;
    logic free_bogus;
    logic used_bit;
    logic merge_go;
    logic merge_ok;
    logic split_more;
  } dp_status_t;

endpackage

// ===== hw/rtl/bba_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// Used for all per-slot metadata stores. No package dependency.
`timescale 1ns / 1ps

module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/bba_datapath.sv =====
// Datapath of the buddy block allocator: metadata RAMs, free list heads,
// working registers and result registers. Driven by bba_ctrl commands.
// Depends on bba_pkg and bba_ram.
`timescale 1ns / 1ps

module bba_datapath #(
  parameter int MIN_ORDER    = bba_pkg::DEF_MIN_ORDER,
  parameter int MAX_ORDER    = bba_pkg::DEF_MAX_ORDER,
  parameter int REGIONS      = bba_pkg::DEF_REGIONS,
  parameter int HEADER_BYTES = bba_pkg::DEF_HEADER_BYTES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bba_pkg::cmd_t                   cmd,
  input  logic [bba_pkg::LEN_W-1:0]       in_req_length,
  input  logic [bba_pkg::ADDR_W-1:0]      in_block_address,
  output bba_pkg::dp_status_t             sts,
  output logic                            out_valid,
  output logic [bba_pkg::ADDR_W-1:0]      out_result_address,
  output logic [bba_pkg::STATUS_W-1:0]    out_status
);

  localparam int OW         = bba_pkg::ORDER_W;
  localparam int AD         = bba_pkg::ADDR_W;
  localparam int SPR_LOG    = MAX_ORDER - MIN_ORDER;
  localparam int SLOT_COUNT = REGIONS << SPR_LOG;
  localparam int SW         = $clog2(SLOT_COUNT + 1);
  localparam int AW         = $clog2(SLOT_COUNT);
  localparam int HW         = $clog2(MAX_ORDER + 1);
  localparam int RGW        = $clog2(REGIONS + 1);
  localparam int TW         = (MAX_ORDER + 2 > AD) ? MAX_ORDER + 2 : AD;
  localparam int CW         = (SW > AD) ? SW : AD;
  localparam int OFFW       = (SW + MIN_ORDER + 1 > AD) ? SW + MIN_ORDER + 1 : AD;
  localparam logic [SW-1:0] NO_SLOT = SW'(SLOT_COUNT);

  logic [bba_pkg::LEN_W-1:0] len_r;
  logic [AD-1:0]             addr_r;
  logic [OW-1:0]             want_r;
  logic [OW-1:0]             k_r;
  logic [SW-1:0]             s_r;
  logic [SW-1:0]             b_r;
  logic [SW-1:0]             u_r;
  logic [SW-1:0]             h_r;
  logic [SW-1:0]             heads_r [MAX_ORDER + 1];
  logic [RGW-1:0]            regions_r;
  logic                      out_valid_r;
  logic [AD-1:0]             out_addr_r;
  logic [bba_pkg::STATUS_W-1:0] out_status_r;

  logic [TW-1:0]   total;
  logic [OW-1:0]   want_calc;
  logic [SW-1:0]   head_k;
  logic [OW-1:0]   k_min;
  logic [SW-1:0]   b_calc;
  logic [AD-1:0]   h_off;
  logic [CW-1:0]   hs_w;
  logic [CW-1:0]   claimed;
  logic [SW-1:0]   s_calc;
  logic [SW-1:0]   sdec_up;
  logic [SW-1:0]   smin;
  logic [OFFW-1:0] fin_addr;
  logic [SW-1:0]   claim_slot;

  logic            re;
  logic [AW-1:0]   raddr;
  logic            ord_we, used_we, next_we, prev_we;
  logic [AW-1:0]   ord_wa, used_wa, next_wa, prev_wa;
  logic [OW-1:0]   ord_wd;
  logic            used_wd;
  logic [SW-1:0]   next_wd, prev_wd;
  logic [OW-1:0]   order_rd;
  logic            used_rd;
  logic [SW-1:0]   next_rd, prev_rd;

  assign total = TW'(len_r) + TW'(HEADER_BYTES);

  always_comb begin
    want_calc = OW'(MAX_ORDER);
    for (int o = MAX_ORDER - 1; o >= MIN_ORDER; o--) begin
      if (total <= (TW'(1) << o)) begin
        want_calc = OW'(o);
      end
    end
  end

  assign head_k     = (k_r <= OW'(MAX_ORDER)) ? heads_r[k_r[HW-1:0]] : NO_SLOT;
  assign k_min      = k_r - OW'(MIN_ORDER);
  assign b_calc     = s_r ^ (SW'(1) << k_min);
  assign h_off      = addr_r - AD'(HEADER_BYTES);
  assign hs_w       = CW'(h_off >> MIN_ORDER);
  assign claimed    = CW'(regions_r) << SPR_LOG;
  assign s_calc     = hs_w[SW-1:0];
  assign sdec_up    = s_r + (SW'(1) << (k_min - OW'(1)));
  assign smin       = (b_r < s_r) ? b_r : s_r;
  assign fin_addr   = (OFFW'(s_r) << MIN_ORDER) + OFFW'(HEADER_BYTES);
  assign claim_slot = SW'(regions_r) << SPR_LOG;

  assign sts.too_large    = (want_calc >= OW'(MAX_ORDER));
  assign sts.head_hit     = (head_k != NO_SLOT);
  assign sts.k_is_max     = (k_r == OW'(MAX_ORDER));
  assign sts.regions_full = (regions_r >= RGW'(REGIONS));
  assign sts.free_bogus   = (addr_r < AD'(HEADER_BYTES))
                         || ((h_off & AD'((1 << MIN_ORDER) - 1)) != '0)
                         || (hs_w >= claimed);
  assign sts.used_bit     = used_rd;
  assign sts.merge_go     = (k_r >= OW'(MIN_ORDER)) && (k_r < OW'(MAX_ORDER))
                         && (b_calc < NO_SLOT);
  assign sts.merge_ok     = !used_rd && (order_rd == k_r);
  assign sts.split_more   = (k_r > want_r);

  always_comb begin
    re      = 1'b0;
    raddr   = s_calc[AW-1:0];
    ord_we  = 1'b0;
    used_we = 1'b0;
    next_we = 1'b0;
    prev_we = 1'b0;
    ord_wa  = s_r[AW-1:0];
    used_wa = s_r[AW-1:0];
    next_wa = b_r[AW-1:0];
    prev_wa = b_r[AW-1:0];
    ord_wd  = k_r;
    used_wd = 1'b0;
    next_wd = NO_SLOT;
    prev_wd = NO_SLOT;
    case (cmd)
      bba_pkg::C_POP: begin
        re    = 1'b1;
        raddr = head_k[AW-1:0];
      end
      bba_pkg::C_FCHK: begin
        re    = 1'b1;
        raddr = s_calc[AW-1:0];
      end
      bba_pkg::C_MBUDDY: begin
        re    = 1'b1;
        raddr = b_calc[AW-1:0];
      end
      bba_pkg::C_CLAIM: begin
        ord_we  = 1'b1;
        used_we = 1'b1;
        next_we = 1'b1;
        prev_we = 1'b1;
        ord_wa  = claim_slot[AW-1:0];
        used_wa = claim_slot[AW-1:0];
        next_wa = claim_slot[AW-1:0];
        prev_wa = claim_slot[AW-1:0];
        ord_wd  = OW'(MAX_ORDER);
      end
      bba_pkg::C_UL_W1: begin
        prev_we = (next_rd < NO_SLOT);
        prev_wa = next_rd[AW-1:0];
        prev_wd = prev_rd;
        next_we = (prev_rd < NO_SLOT);
        next_wa = prev_rd[AW-1:0];
        next_wd = next_rd;
      end
      bba_pkg::C_UL_W2: begin
        next_we = 1'b1;
        prev_we = 1'b1;
        next_wa = u_r[AW-1:0];
        prev_wa = u_r[AW-1:0];
      end
      bba_pkg::C_PUSH1: begin
        next_we = 1'b1;
        prev_we = 1'b1;
        next_wd = head_k;
      end
      bba_pkg::C_PUSH1M: begin
        next_we = 1'b1;
        prev_we = 1'b1;
        next_wd = head_k;
        ord_we  = 1'b1;
        used_we = 1'b1;
        ord_wa  = b_r[AW-1:0];
        used_wa = b_r[AW-1:0];
      end
      bba_pkg::C_PUSH2, bba_pkg::C_PUSH2F: begin
        prev_we = (h_r < NO_SLOT);
        prev_wa = h_r[AW-1:0];
        prev_wd = b_r;
      end
      bba_pkg::C_FINAL: begin
        ord_we  = 1'b1;
        used_we = 1'b1;
        ord_wd  = want_r;
        used_wd = 1'b1;
      end
      bba_pkg::C_FUSED: begin
        used_we = 1'b1;
      end
      bba_pkg::C_MUP: begin
        ord_we = 1'b1;
        ord_wa = smin[AW-1:0];
        ord_wd = k_r + OW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    out_valid_r <= 1'b0;
    case (cmd)
      bba_pkg::C_LOAD: begin
        len_r  <= in_req_length;
        addr_r <= in_block_address;
      end
      bba_pkg::C_SIZE: begin
        want_r <= want_calc;
        k_r    <= want_calc;
      end
      bba_pkg::C_SCAN_INC: k_r <= k_r + OW'(1);
      bba_pkg::C_CLAIM: begin
        s_r       <= claim_slot;
        regions_r <= regions_r + RGW'(1);
        k_r       <= OW'(MAX_ORDER);
      end
      bba_pkg::C_POP: begin
        s_r <= head_k;
        u_r <= head_k;
      end
      bba_pkg::C_UL_W1: begin
        if (prev_rd >= NO_SLOT && order_rd == k_r && head_k == u_r) begin
          heads_r[k_r[HW-1:0]] <= next_rd;
        end
      end
      bba_pkg::C_FCHK:  s_r <= s_calc;
      bba_pkg::C_FUSED: k_r <= order_rd;
      bba_pkg::C_MBUDDY: begin
        b_r <= b_calc;
        u_r <= b_calc;
      end
      bba_pkg::C_MUP: begin
        s_r <= smin;
        k_r <= k_r + OW'(1);
      end
      bba_pkg::C_FPREP: begin
        b_r <= s_r;
        if (k_r > OW'(MAX_ORDER)) begin
          k_r <= OW'(MAX_ORDER);
        end
      end
      bba_pkg::C_SDEC: begin
        k_r <= k_r - OW'(1);
        b_r <= sdec_up;
      end
      bba_pkg::C_PUSH1, bba_pkg::C_PUSH1M: h_r <= head_k;
      bba_pkg::C_PUSH2: heads_r[k_r[HW-1:0]] <= b_r;
      bba_pkg::C_PUSH2F: begin
        heads_r[k_r[HW-1:0]] <= b_r;
        out_valid_r  <= 1'b1;
        out_addr_r   <= '0;
        out_status_r <= bba_pkg::STATUS_OK;
      end
      bba_pkg::C_FINAL: begin
        out_valid_r  <= 1'b1;
        out_addr_r   <= fin_addr[AD-1:0];
        out_status_r <= bba_pkg::STATUS_OK;
      end
      bba_pkg::C_R_OK: begin
        out_valid_r  <= 1'b1;
        out_addr_r   <= '0;
        out_status_r <= bba_pkg::STATUS_OK;
      end
      bba_pkg::C_R_BIG: begin
        out_valid_r  <= 1'b1;
        out_addr_r   <= '0;
        out_status_r <= bba_pkg::STATUS_TOO_LARGE;
      end
      bba_pkg::C_R_OOM: begin
        out_valid_r  <= 1'b1;
        out_addr_r   <= '0;
        out_status_r <= bba_pkg::STATUS_NO_MEM;
      end
      default: begin
      end
    endcase
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      regions_r   <= '0;
      for (int i = 0; i <= MAX_ORDER; i++) begin
        heads_r[i] <= NO_SLOT;
      end
    end
  end

  bba_ram #(.WIDTH(OW), .DEPTH(SLOT_COUNT)) u_order_ram (
    .clk(clk), .we(ord_we), .waddr(ord_wa), .wdata(ord_wd),
    .re(re), .raddr(raddr), .rdata(order_rd)
  );

  bba_ram #(.WIDTH(1), .DEPTH(SLOT_COUNT)) u_used_ram (
    .clk(clk), .we(used_we), .waddr(used_wa), .wdata(used_wd),
    .re(re), .raddr(raddr), .rdata(used_rd)
  );

  bba_ram #(.WIDTH(SW), .DEPTH(SLOT_COUNT)) u_next_ram (
    .clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
    .re(re), .raddr(raddr), .rdata(next_rd)
  );

  bba_ram #(.WIDTH(SW), .DEPTH(SLOT_COUNT)) u_prev_ram (
    .clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
    .re(re), .raddr(raddr), .rdata(prev_rd)
  );

  assign out_valid          = out_valid_r;
  assign out_result_address = out_addr_r;
  assign out_status         = out_status_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r) else $error("result strobe held two cycles");

  a_regions_bound: assert property (@(posedge clk) disable iff (!rst_n)
    regions_r <= RGW'(REGIONS)) else $error("claimed more regions than exist");

  a_head_index: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == bba_pkg::C_PUSH2 || cmd == bba_pkg::C_PUSH2F) |-> k_r <= OW'(MAX_ORDER))
    else $error("free list push at an order beyond the top");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != bba_pkg::STATUS_OK) |-> out_addr_r == '0)
    else $error("failed request returned an address");

endmodule

// ===== hw/rtl/bba_ctrl.sv =====
// Controller state machine of the buddy block allocator.
// Sequences the size, scan, split, unlink, merge and push steps as datapath
// commands. Depends on bba_pkg.
`timescale 1ns / 1ps

module bba_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_opcode,
  input  bba_pkg::dp_status_t sts,
  output logic                busy,
  output bba_pkg::cmd_t       cmd
);

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_SIZE  = 13'b0000000000010,
    ST_SCAN  = 13'b0000000000100,
    ST_UL1   = 13'b0000000001000,
    ST_UL2   = 13'b0000000010000,
    ST_SDEC  = 13'b0000000100000,
    ST_P1    = 13'b0000001000000,
    ST_P2    = 13'b0000010000000,
    ST_FCHK  = 13'b0000100000000,
    ST_FUSED = 13'b0001000000000,
    ST_MLOOP = 13'b0010000000000,
    ST_MCHK  = 13'b0100000000000,
    ST_MUP   = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   opc_r, opc_nxt;

  always_comb begin
    state_nxt = state_r;
    opc_nxt   = opc_r;
    cmd       = bba_pkg::C_NOP;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd       = bba_pkg::C_LOAD;
          opc_nxt   = in_opcode;
          state_nxt = (in_opcode == bba_pkg::OP_FREE) ? ST_FCHK : ST_SIZE;
        end
      end
      ST_SIZE: begin
        if (sts.too_large) begin
          cmd       = bba_pkg::C_R_BIG;
          state_nxt = ST_IDLE;
        end else begin
          cmd       = bba_pkg::C_SIZE;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.head_hit) begin
          cmd       = bba_pkg::C_POP;
          state_nxt = ST_UL1;
        end else if (sts.k_is_max) begin
          if (sts.regions_full) begin
            cmd       = bba_pkg::C_R_OOM;
            state_nxt = ST_IDLE;
          end else begin
            cmd       = bba_pkg::C_CLAIM;
            state_nxt = ST_SDEC;
          end
        end else begin
          cmd = bba_pkg::C_SCAN_INC;
        end
      end
      ST_UL1: begin
        cmd       = bba_pkg::C_UL_W1;
        state_nxt = ST_UL2;
      end
      ST_UL2: begin
        cmd       = bba_pkg::C_UL_W2;
        state_nxt = (opc_r == bba_pkg::OP_FREE) ? ST_MUP : ST_SDEC;
      end
      ST_SDEC: begin
        if (sts.split_more) begin
          cmd       = bba_pkg::C_SDEC;
          state_nxt = ST_P1;
        end else begin
          cmd       = bba_pkg::C_FINAL;
          state_nxt = ST_IDLE;
        end
      end
      ST_P1: begin
        cmd       = (opc_r == bba_pkg::OP_FREE) ? bba_pkg::C_PUSH1 : bba_pkg::C_PUSH1M;
        state_nxt = ST_P2;
      end
      ST_P2: begin
        if (opc_r == bba_pkg::OP_FREE) begin
          cmd       = bba_pkg::C_PUSH2F;
          state_nxt = ST_IDLE;
        end else begin
          cmd       = bba_pkg::C_PUSH2;
          state_nxt = ST_SDEC;
        end
      end
      ST_FCHK: begin
        if (sts.free_bogus) begin
          cmd       = bba_pkg::C_R_OK;
          state_nxt = ST_IDLE;
        end else begin
          cmd       = bba_pkg::C_FCHK;
          state_nxt = ST_FUSED;
        end
      end
      ST_FUSED: begin
        if (!sts.used_bit) begin
          cmd       = bba_pkg::C_R_OK;
          state_nxt = ST_IDLE;
        end else begin
          cmd       = bba_pkg::C_FUSED;
          state_nxt = ST_MLOOP;
        end
      end
      ST_MLOOP: begin
        if (sts.merge_go) begin
          cmd       = bba_pkg::C_MBUDDY;
          state_nxt = ST_MCHK;
        end else begin
          cmd       = bba_pkg::C_FPREP;
          state_nxt = ST_P1;
        end
      end
      ST_MCHK: begin
        if (sts.merge_ok) begin
          state_nxt = ST_UL1;
        end else begin
          cmd       = bba_pkg::C_FPREP;
          state_nxt = ST_P1;
        end
      end
      ST_MUP: begin
        cmd       = bba_pkg::C_MUP;
        state_nxt = ST_MLOOP;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      opc_r   <= bba_pkg::OP_ALLOC;
    end else begin
      state_r <= state_nxt;
      opc_r   <= opc_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted transaction did not start work");

  a_unlink_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UL1) |=> (state_r == ST_UL2)) else $error("unlink cut short");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == bba_pkg::C_FINAL || cmd == bba_pkg::C_R_OK || cmd == bba_pkg::C_PUSH2F)
    |=> (state_r == ST_IDLE)) else $error("result issued without returning to idle");

endmodule

// ===== hw/rtl/buddy_block_allocator.sv =====
// Channel   | Ports                                         | Handshake
// command   | start, busy, in_opcode, in_req_length,        | start && !busy
//           | in_block_address                              |
// result    | out_valid, out_result_address, out_status     | out_valid, one cycle
//
// An allocate keeps busy high through the size step, the scan over empty
// orders, an unlink or a region claim, and each split. A free runs through the
// address check, the used check, each merge and the final push; a rejected
// free ends at one of the two checks. The walk over orders through the single
// read port of the metadata RAMs sets how long this takes.
// busy is high from acceptance until the cycle the result strobe shows.
// rst_n is synchronous; after it every free list is empty and no region is
// claimed. The receiver cannot stall; each result is shown for one cycle.
// Top level; depends on bba_pkg, bba_ctrl and bba_datapath.
`timescale 1ns / 1ps

module buddy_block_allocator #(
  parameter int MIN_ORDER    = bba_pkg::DEF_MIN_ORDER,
  parameter int MAX_ORDER    = bba_pkg::DEF_MAX_ORDER,
  parameter int REGIONS      = bba_pkg::DEF_REGIONS,
  parameter int HEADER_BYTES = bba_pkg::DEF_HEADER_BYTES
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_opcode,
  input  logic [bba_pkg::LEN_W-1:0]    in_req_length,
  input  logic [bba_pkg::ADDR_W-1:0]   in_block_address,
  output logic                         out_valid,
  output logic [bba_pkg::ADDR_W-1:0]   out_result_address,
  output logic [bba_pkg::STATUS_W-1:0] out_status
);

  bba_pkg::cmd_t       cmd;
  bba_pkg::dp_status_t sts;

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (in_opcode),
    .sts       (sts),
    .busy      (busy),
    .cmd       (cmd)
  );

  bba_datapath #(
    .MIN_ORDER    (MIN_ORDER),
    .MAX_ORDER    (MAX_ORDER),
    .REGIONS      (REGIONS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_req_length      (in_req_length),
    .in_block_address   (in_block_address),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_result_address (out_result_address),
    .out_status         (out_status)
  );

endmodule
